### hdl/spd_pkg.sv
// Package for the sensor packet deframer: packet geometry, window and result types.
// Used by spd_frame_eval and sensor_packet_deframer; has no dependencies.
package spd_pkg;

    localparam int PKT_LEN  = 14;
    localparam int SUM_LAST = 12;
    localparam int CHK_POS  = 13;

    localparam logic [7:0] HEADER_RESET = 8'h55;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_fill;
    typedef logic [PKT_LEN-1:0][7:0] t_window;

    localparam t_fill FILL_FULL = t_fill'(PKT_LEN);

    typedef struct packed {
        logic        hit;
        logic [31:0] left_count;
        logic [31:0] right_count;
        logic [31:0] yaw_bits;
    } t_frame_res;

endpackage

### hdl/spd_frame_eval.sv
// Single-pass evaluation of one received byte against the packet window:
// append, header search, resync shift, checksum and field extraction. Uses spd_pkg.
module spd_frame_eval (
    input  spd_pkg::t_window    i_win,
    input  spd_pkg::t_fill      i_fill,
    input  spd_pkg::t_byte      i_byte,
    input  spd_pkg::t_byte      i_header,
    output spd_pkg::t_window    o_next_win,
    output spd_pkg::t_fill      o_next_fill,
    output spd_pkg::t_frame_res o_res
);

    spd_pkg::t_window w_full;
    spd_pkg::t_fill   w_fill_eff;
    spd_pkg::t_fill   w_fill_inc;
    spd_pkg::t_fill   w_hdr_pos;
    spd_pkg::t_fill   w_shift;
    logic             w_hdr_found;
    logic [7:0]       w_sum_lo;
    logic [7:0]       w_sum_hi;
    logic [7:0]       w_sum;

    always_comb begin
        w_fill_eff = (i_fill >= spd_pkg::FILL_FULL) ? '0 : i_fill;
        w_full = i_win;
        w_full[w_fill_eff] = i_byte;
        w_fill_inc = w_fill_eff + 4'd1;

        // priority search: lowest matching position wins
        w_hdr_found = 1'b0;
        w_hdr_pos   = '0;
        for (int k = spd_pkg::PKT_LEN - 1; k >= 0; k--) begin
            if (w_full[k] == i_header) begin
                w_hdr_found = 1'b1;
                w_hdr_pos   = spd_pkg::t_fill'(k);
            end
        end

        // checksum over bytes 1..12 as two six-byte halves
        w_sum_lo = '0;
        w_sum_hi = '0;
        for (int k = 1; k <= spd_pkg::SUM_LAST / 2; k++) begin
            w_sum_lo = w_sum_lo + w_full[k];
            w_sum_hi = w_sum_hi + w_full[k + spd_pkg::SUM_LAST / 2];
        end
        w_sum = w_sum_lo + w_sum_hi;

        o_next_fill = w_fill_inc;
        w_shift     = '0;
        o_res.hit   = 1'b0;
        if (w_fill_inc == spd_pkg::FILL_FULL) begin
            if (!w_hdr_found) begin
                o_next_fill = '0;
            end else if (w_hdr_pos != '0) begin
                // drop leading bytes before the header
                w_shift     = w_hdr_pos;
                o_next_fill = spd_pkg::FILL_FULL - w_hdr_pos;
            end else if (w_sum != w_full[spd_pkg::CHK_POS]) begin
                // drop the false header and try again
                w_shift     = 4'd1;
                o_next_fill = spd_pkg::FILL_FULL - 4'd1;
            end else begin
                o_res.hit   = 1'b1;
                o_next_fill = '0;
            end
        end

        for (int i = 0; i < spd_pkg::PKT_LEN; i++) begin
            o_next_win[i] = w_full[i];
            for (int j = 1; j < spd_pkg::PKT_LEN - i; j++) begin
                if (w_shift == spd_pkg::t_fill'(j)) begin
                    o_next_win[i] = w_full[i + j];
                end
            end
        end

        o_res.left_count  = {w_full[4], w_full[3], w_full[2], w_full[1]};
        o_res.right_count = {w_full[8], w_full[7], w_full[6], w_full[5]};
        o_res.yaw_bits    = {w_full[12], w_full[11], w_full[10], w_full[9]};
    end

endmodule

### hdl/sensor_packet_deframer.sv
// Sensor packet deframer top level: input register, window state, result register.
// Depends on spd_pkg and spd_frame_eval.
// A good packet's last byte goes to the input register, its result to the result register.
// Throughput: one byte per cycle while the result side takes transactions; the window
// update is one pass of the evaluator between the input and result registers.
// Reset (synchronous, active low): window empty, no transactions pending, header 0x55.
module sensor_packet_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_left_count,
    output logic signed [31:0] o_right_count,
    output logic [31:0]        o_yaw_bits
);

    spd_pkg::t_byte      r_hdr;
    logic                r_in_valid;
    spd_pkg::t_byte      r_in_byte;
    spd_pkg::t_window    r_win;
    spd_pkg::t_fill      r_fill;
    logic                r_out_valid;
    logic [31:0]         r_left;
    logic [31:0]         r_right;
    logic [31:0]         r_yaw;

    spd_pkg::t_window    n_win;
    spd_pkg::t_fill      n_fill;
    spd_pkg::t_frame_res w_res;
    logic                w_adv;
    logic                w_step;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_adv;
    assign o_rx_ready = !r_in_valid || w_adv;

    spd_frame_eval u_eval (
        .i_win       (r_win),
        .i_fill      (r_fill),
        .i_byte      (r_in_byte),
        .i_header    (r_hdr),
        .o_next_win  (n_win),
        .o_next_fill (n_fill),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= spd_pkg::HEADER_RESET;
        end else if (i_cfg_we) begin
            r_hdr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (w_step) begin
                r_fill <= n_fill;
            end
            // hold a waiting result until the output transaction completes
            if (w_adv) begin
                r_out_valid <= w_step && w_res.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_step) begin
            r_win <= n_win;
        end
        if (w_step && w_res.hit) begin
            r_left  <= w_res.left_count;
            r_right <= w_res.right_count;
            r_yaw   <= w_res.yaw_bits;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_count  = signed'(r_left);
    assign o_right_count = signed'(r_right);
    assign o_yaw_bits    = r_yaw;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < spd_pkg::FILL_FULL)
        else $error("window fill count reached packet length");

    a_hit_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res.hit) |=> (r_fill == '0) && r_out_valid)
        else $error("good packet did not empty the window");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a pending result");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a processed byte");

endmodule

### test/spd_frame_checker.sv
// Frame checker for the sensor packet deframer: tracks the byte window, predicts decoded frames.
// Compares each result transaction with the oldest predicted frame and counts failures.
// Depends on spd_pkg for the packet geometry, the header reset value and the byte type.
module spd_frame_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_rx_valid,
    input  logic               i_rx_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    input  logic [31:0]        i_yaw_bits,
    output int                 o_fail_count,
    output int                 o_frames_pending,
    output int                 o_frames_seen
);

    typedef struct {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [31:0]        yaw_bits;
    } t_odo_frame;

    spd_pkg::t_byte win [spd_pkg::PKT_LEN];
    int             fill;
    spd_pkg::t_byte header;
    t_odo_frame     frame_q [$];

    function automatic logic [31:0] le_word(input int pos);
        return {win[pos+3], win[pos+2], win[pos+1], win[pos]};
    endfunction

    task automatic discard_front(input int n);
        for (int i = 0; i < fill - n; i++) begin
            win[i] = win[i+n];
        end
        fill = fill - n;
    endtask

    // Append one byte to the window and queue the frame it completes, if any.
    task automatic deframe_byte(input spd_pkg::t_byte b);
        int             h;
        spd_pkg::t_byte sum;
        t_odo_frame     f;
        if (fill >= spd_pkg::PKT_LEN) fill = 0;
        win[fill] = b;
        fill++;
        if (fill < spd_pkg::PKT_LEN) return;
        h = 0;
        while (h < spd_pkg::PKT_LEN && win[h] != header) h++;
        if (h == spd_pkg::PKT_LEN) begin
            fill = 0;
            return;
        end
        if (h != 0) begin
            // resync: drop everything in front of the first header
            discard_front(h);
            return;
        end
        sum = '0;
        for (int i = 1; i <= spd_pkg::SUM_LAST; i++) begin
            sum = sum + win[i];
        end
        if (sum != win[spd_pkg::CHK_POS]) begin
            discard_front(1);
            return;
        end
        f.left_count  = le_word(1);
        f.right_count = le_word(5);
        f.yaw_bits    = le_word(9);
        frame_q.push_back(f);
        fill = 0;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                   input logic [31:0] act_val);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_val, act_val);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_odo_frame exp_frame;
        if (!i_rst_n) begin
            fill          = 0;
            header        = spd_pkg::HEADER_RESET;
            frame_q.delete();
            o_fail_count  = 0;
            o_frames_seen = 0;
        end else begin
            if (i_cfg_we) header = i_cfg_data;
            if (i_rx_valid && i_rx_ready) deframe_byte(i_rx_byte);
            if (i_out_valid && i_out_ready) begin
                o_frames_seen++;
                if (frame_q.size() == 0) begin
                    $display("%0t: unexpected frame: expected none, actual %h %h %h", $time,
                             i_left_count, i_right_count, i_yaw_bits);
                    o_fail_count++;
                end else begin
                    exp_frame = frame_q.pop_front();
                    if (i_left_count !== exp_frame.left_count)
                        report_mismatch("left_count", exp_frame.left_count, i_left_count);
                    if (i_right_count !== exp_frame.right_count)
                        report_mismatch("right_count", exp_frame.right_count, i_right_count);
                    if (i_yaw_bits !== exp_frame.yaw_bits)
                        report_mismatch("yaw_bits", exp_frame.yaw_bits, i_yaw_bits);
                end
            end
        end
        o_frames_pending = frame_q.size();
    end

endmodule

### test/tb_top.sv
// Testbench top for sensor_packet_deframer: clock, reset, byte and header stimulus, verdict.
// Depends on spd_pkg, the deframer RTL and spd_frame_checker, which predicts and compares.
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 400;
    localparam int NUM_PHASES     = 5;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_data  = 8'h00;
    logic               rx_valid  = 1'b0;
    logic               rx_ready;
    logic [7:0]         rx_byte   = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        yaw_bits;

    int         fail_count;
    int         frames_pending;
    int         frames_seen;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         bytes_sent     = 0;
    int         quiet_cycles   = 0;
    logic [7:0] cur_header     = spd_pkg::HEADER_RESET;

    sensor_packet_deframer uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_rx_valid    (rx_valid),
        .o_rx_ready    (rx_ready),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_left_count  (left_count),
        .o_right_count (right_count),
        .o_yaw_bits    (yaw_bits)
    );

    spd_frame_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_rx_valid       (rx_valid),
        .i_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_left_count     (left_count),
        .i_right_count    (right_count),
        .i_yaw_bits       (yaw_bits),
        .o_fail_count     (fail_count),
        .o_frames_pending (frames_pending),
        .o_frames_seen    (frames_seen)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run if neither channel moves a transaction for too long.
    always @(posedge clk) begin
        if (!rst_n || (rx_valid && rx_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance, valid still high.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet(input logic signed [31:0] l, input logic signed [31:0] r,
                               input logic [31:0] y, input bit corrupt);
        logic [7:0] body [12];
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < 4; i++) begin
            body[i]   = l[8*i +: 8];
            body[4+i] = r[8*i +: 8];
            body[8+i] = y[8*i +: 8];
        end
        for (int i = 0; i < 12; i++) sum = sum + body[i];
        if (corrupt) sum = sum ^ (8'h01 << $urandom_range(7));
        send_byte(cur_header);
        for (int i = 0; i < 12; i++) send_byte(body[i]);
        send_byte(sum);
    endtask

    // Hold the sender off until every predicted frame is out and the pipeline is empty.
    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (frames_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_header(input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we     <= 1'b0;
        cur_header  = v;
        @(negedge clk);
    endtask

    task automatic run_phase(input int n_bytes);
        int start;
        int kind;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                send_packet($urandom, $urandom, $urandom, 1'b0);
            end else if (kind < 77) begin
                send_packet($urandom, $urandom, $urandom, 1'b1);
            end else if (kind < 87) begin
                len = $urandom_range(20, 1);
                repeat (len) send_byte($urandom_range(255));
            end else if (kind < 95) begin
                // truncated packet: header plus a partial body
                send_byte(cur_header);
                len = $urandom_range(12, 1);
                repeat (len) send_byte($urandom_range(255));
            end else begin
                len = $urandom_range(3, 1);
                repeat (len) send_byte(cur_header);
            end
            if ($urandom_range(63) == 0) begin
                rx_valid <= 1'b0;
                while (frames_pending != 0) @(negedge clk);
            end
        end
    endtask

    initial begin
        logic [7:0] headers [NUM_PHASES];
        headers[0] = 8'hFF;
        headers[1] = 8'h00;
        headers[2] = 8'hA5;
        headers[3] = $urandom_range(255);
        headers[4] = spd_pkg::HEADER_RESET;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: leading junk, all-ones and sign-extreme frames, a bad checksum,
        // a headerless run, then an all-zero frame. Header is the reset value here.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h12);
        send_packet(-32'sd1, -32'sd1, 32'hFFFF_FFFF, 1'b0);
        send_packet(32'sh8000_0000, 32'sh7FFF_FFFF, 32'h7F80_0000, 1'b0);
        send_packet(32'sd0, 32'sd0, 32'h0000_0000, 1'b1);
        repeat (14) send_byte(8'h00);
        send_packet(32'sd0, 32'sd0, 32'h0000_0000, 1'b0);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_header(headers[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            run_phase(PHASE_BYTES);
            wait_idle();
        end

        $display("Run covered %0d received bytes under five header values and four",
                 bytes_sent);
        $display("flow-control mixes; %0d decoded frames were checked.", frames_seen);
        if (fail_count == 0 && frames_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/spd_pkg.sv
hdl/spd_frame_eval.sv
hdl/sensor_packet_deframer.sv
test/spd_frame_checker.sv
test/tb_top.sv
